// File: design/spi_flash_command_sequencer_unit_defines.svh
// assertion helpers, clocked on clk and disabled in reset
`ifndef SPI_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

`define SFCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define SFCS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: design/sfcs_pkg.sv
package sfcs_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int ADDRESS_WIDTH = 24;
	localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int FRAME_MAX = 6;

	localparam logic [2:0] REQ_UNLOCK = 3'd0;
	localparam logic [2:0] REQ_ERASE = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_READ = 3'd3;
	localparam logic [2:0] REQ_READID = 3'd4;
	localparam logic [2:0] REQ_DONE = 3'd5;
	localparam logic [2:0] REQ_LOAD = 3'd6;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_UNLOCK = 3'd1;
	localparam logic [2:0] M_ERASE = 3'd2;
	localparam logic [2:0] M_WRITE = 3'd3;
	localparam logic [2:0] M_READ = 3'd4;
	localparam logic [2:0] M_READID = 3'd5;

	localparam logic [7:0] OP_EWSR = 8'h50;
	localparam logic [7:0] OP_WRSR = 8'h01;
	localparam logic [7:0] OP_WREN = 8'h06;
	localparam logic [7:0] OP_WRDI = 8'h04;
	localparam logic [7:0] OP_RDSR = 8'h05;
	localparam logic [7:0] OP_ERASE = 8'h60;
	localparam logic [7:0] OP_BPROG = 8'h02;
	localparam logic [7:0] OP_AAI = 8'hAD;
	localparam logic [7:0] OP_READ = 8'h0B;
	localparam logic [7:0] OP_RDID = 8'h90;

	typedef struct packed {
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [2:0] cnt;
		logic [8:0] rx;
	} sfcs_frame_t;

endpackage

// File: design/sfcs_front.sv
`include "spi_flash_command_sequencer_unit_defines.svh"

module sfcs_front import sfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic [7:0]  length,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  status_byte,
	output logic        q_push,
	output sfcs_frame_t q_frame,
	input  logic        q_full
);

	localparam logic [9:0] DEPTH_W = 10'(BUFFER_DEPTH);

	logic [2:0] mode_q, n_mode;
	logic [1:0] step_q, n_step;
	logic [ADDRESS_WIDTH-1:0] addr_q, n_addr;
	logic [BUF_AW-1:0] li_q, n_li;
	logic [7:0] wl_q, n_wl;
	logic [8:0] wi_q, n_wi, wi1;
	logic srp_q, n_srp;
	sfcs_frame_t hold_q, fr;
	logic hold_v_q, fetch_q, fhi_q, take1_q;
	logic emit, fetch, fhi, take1, mem_we;
	logic [7:0] rd0_q, rd1_q, b0v, b1v;
	logic rv0_q, rv1_q;
	logic [7:0] mem [BUFFER_DEPTH];
	logic accept;
	logic [8:0] rem;
	logic two;
	logic [23:0] a24;

	assign full = hold_v_q & q_full;
	assign accept = push & ~full;
	assign wi1 = wi_q + 9'd1;
	assign rem = (wi_q < {1'b0, wl_q}) ? ({1'b0, wl_q} - wi_q) : 9'd0;
	assign two = rem >= 9'd2;
	assign a24 = 24'(addr_q);

	always_comb begin
		n_mode = mode_q;
		n_step = step_q;
		n_addr = addr_q;
		n_li = li_q;
		n_wl = wl_q;
		n_wi = wi_q;
		emit = 1'b0;
		fetch = 1'b0;
		fhi = 1'b0;
		take1 = 1'b0;
		mem_we = 1'b0;
		fr = '0;
		unique case (req_type) inside
			REQ_DONE: begin
				unique case (mode_q)
					M_UNLOCK: begin
						if (step_q != 2'd0) begin
							n_mode = M_IDLE;
						end else begin
							n_step = 2'd1;
							emit = 1'b1;
							fr.bytes[0] = OP_WRSR;
							fr.cnt = 3'd2;
						end
					end
					M_ERASE: begin
						if (step_q == 2'd0) begin
							n_step = 2'd1;
							emit = 1'b1;
							fr.bytes[0] = OP_ERASE;
							fr.cnt = 3'd1;
						end else if (step_q == 2'd1) begin
							emit = 1'b1;
							fr.cnt = 3'd1;
							if (srp_q && !status_byte[0]) begin
								n_step = 2'd2;
								fr.bytes[0] = OP_WRDI;
							end else begin
								fr.bytes[0] = OP_RDSR;
								fr.rx = 9'd2;
							end
						end else begin
							n_mode = M_IDLE;
						end
					end
					M_WRITE: begin
						unique case (step_q)
							2'd0: begin
								n_step = 2'd1;
								emit = 1'b1;
								fetch = 1'b1;
								fhi = 1'b1;
								take1 = two;
								fr.bytes[0] = two ? OP_AAI : OP_BPROG;
								fr.bytes[1] = a24[23:16];
								fr.bytes[2] = a24[15:8];
								fr.bytes[3] = a24[7:0];
								fr.cnt = two ? 3'd6 : 3'd5;
								n_wi = two ? wi_q + 9'd2 : wi1;
							end
							2'd1: begin
								n_step = 2'd2;
								emit = 1'b1;
								fr.bytes[0] = OP_RDSR;
								fr.cnt = 3'd1;
								fr.rx = 9'd2;
							end
							2'd2: begin
								emit = 1'b1;
								if (status_byte[0]) begin
									fr.bytes[0] = OP_RDSR;
									fr.cnt = 3'd1;
									fr.rx = 9'd2;
								end else if (rem == 9'd0) begin
									n_step = 2'd3;
									fr.bytes[0] = OP_WRDI;
									fr.cnt = 3'd1;
								end else begin
									n_step = 2'd1;
									fetch = 1'b1;
									take1 = two;
									fr.bytes[0] = OP_AAI;
									fr.cnt = 3'd3;
									n_wi = two ? wi_q + 9'd2 : wi1;
								end
							end
							default: begin
								n_addr = addr_q + ADDRESS_WIDTH'(wl_q);
								n_mode = M_IDLE;
							end
						endcase
					end
					default: n_mode = M_IDLE;
				endcase
			end
			REQ_LOAD: begin
				if (mode_q != M_WRITE) begin
					mem_we = 1'b1;
					n_li = (li_q == BUF_AW'(BUFFER_DEPTH - 1)) ? '0 : li_q + 1'b1;
				end
			end
			REQ_UNLOCK, REQ_ERASE, REQ_WRITE, REQ_READ, REQ_READID: begin
				if (mode_q == M_IDLE) begin
					n_step = 2'd0;
					emit = 1'b1;
					fr.cnt = 3'd1;
					unique case (req_type)
						REQ_UNLOCK: begin
							n_mode = M_UNLOCK;
							fr.bytes[0] = OP_EWSR;
						end
						REQ_ERASE: begin
							n_mode = M_ERASE;
							fr.bytes[0] = OP_WREN;
						end
						REQ_WRITE: begin
							if (length == 8'd0) begin
								emit = 1'b0;
							end else begin
								n_mode = M_WRITE;
								n_wl = length;
								n_wi = '0;
								n_li = '0;
								fr.bytes[0] = OP_WREN;
							end
						end
						REQ_READ: begin
							n_mode = M_READ;
							fr.bytes[0] = OP_READ;
							fr.bytes[1] = a24[23:16];
							fr.bytes[2] = a24[15:8];
							fr.bytes[3] = a24[7:0];
							fr.cnt = 3'd5;
							fr.rx = {1'b0, length} + 9'd5;
						end
						default: begin
							n_mode = M_READID;
							fr.bytes[0] = OP_RDID;
							fr.cnt = 3'd4;
							fr.rx = 9'd8;
						end
					endcase
				end
			end
			default: ;
		endcase
		n_srp = (fr.rx == 9'd2) && (fr.cnt == 3'd1) && (fr.bytes[0] == OP_RDSR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			step_q <= '0;
			addr_q <= '0;
			li_q <= '0;
			wl_q <= '0;
			wi_q <= '0;
			srp_q <= 1'b0;
			hold_v_q <= 1'b0;
			fetch_q <= 1'b0;
		end else begin
			if (q_push) begin
				hold_v_q <= 1'b0;
			end
			if (accept) begin
				mode_q <= n_mode;
				step_q <= n_step;
				addr_q <= n_addr;
				li_q <= n_li;
				wl_q <= n_wl;
				wi_q <= n_wi;
				if (emit) begin
					srp_q <= n_srp;
					hold_v_q <= 1'b1;
					fetch_q <= fetch;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			hold_q <= fr;
			fhi_q <= fhi;
			take1_q <= take1;
		end
		if (accept) begin
			if (mem_we) begin
				mem[li_q] <= data_byte;
			end
			rd0_q <= mem[wi_q[BUF_AW-1:0]];
			rd1_q <= mem[wi1[BUF_AW-1:0]];
			rv0_q <= {1'b0, wi_q} < DEPTH_W;
			rv1_q <= {1'b0, wi1} < DEPTH_W;
		end
	end

	assign b0v = rv0_q ? rd0_q : 8'h00;
	assign b1v = (take1_q && rv1_q) ? rd1_q : 8'h00;
	assign q_push = hold_v_q & ~q_full;

	always_comb begin
		q_frame = hold_q;
		if (fetch_q) begin
			if (fhi_q) begin
				q_frame.bytes[4] = b0v;
				q_frame.bytes[5] = b1v;
			end else begin
				q_frame.bytes[1] = b0v;
				q_frame.bytes[2] = b1v;
			end
		end
	end

	`SFCS_ASSERT(a_push_has_frame, q_push |-> (hold_q.cnt != 3'd0), "pushed frame has no bytes")

endmodule

// File: design/sfcs_fifo.sv
`include "spi_flash_command_sequencer_unit_defines.svh"

module sfcs_fifo import sfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  sfcs_frame_t wdata,
	output logic        q_full,
	input  logic        rd,
	output sfcs_frame_t head,
	output logic        q_empty
);

	sfcs_frame_t ent_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0] cnt_q;

	assign q_full = cnt_q == (Q_AW + 1)'(Q_DEPTH);
	assign q_empty = cnt_q == '0;
	assign head = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW + 1)'(wr) - (Q_AW + 1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

	`SFCS_ASSERT_NEVER(a_no_overflow, wr && q_full, "frame pushed into full queue")
	`SFCS_ASSERT_NEVER(a_no_underflow, rd && q_empty, "frame popped from empty queue")

endmodule

// File: design/sfcs_back.sv
`include "spi_flash_command_sequencer_unit_defines.svh"

module sfcs_back import sfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sfcs_frame_t head,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  tx_byte,
	output logic        frame_last,
	output logic [8:0]  rx_length
);

	logic out_v_q;
	logic [2:0] idx_q;
	logic ld, last;

	assign ld = ~out_v_q | pop;
	assign last = idx_q == head.cnt - 3'd1;
	assign q_pop = ld & ~q_empty & last;
	assign empty = ~out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q <= '0;
		end else if (ld) begin
			out_v_q <= ~q_empty;
			if (!q_empty) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld && !q_empty) begin
			tx_byte <= head.bytes[idx_q];
			frame_last <= last;
			rx_length <= head.rx;
		end
	end

	`SFCS_ASSERT(a_idx_in_frame, !q_empty |-> (idx_q < head.cnt), "byte index past frame end")

endmodule

// File: design/spi_flash_command_sequencer_unit.sv
// SPI NOR flash command sequencer. Requests and frame-done events enter through the push/full
// side, one word per cycle while full is low; each accepted word is classified combinationally
// and its frame, if any, goes to a hold register and then into a four-entry frame queue when
// the queue has room. Frames that carry write-buffer data read the buffer memory as the word is
// accepted, so they take no longer. The back end hands out one frame byte per cycle, while pop
// is held, on the empty/pop side; a frame's first byte passes the hold register, the frame queue
// and the output byte register. full rises only while the queue is full and a finished frame
// waits. Reset does not clear the write buffer; a write sends entries 0 to length-1 as stored.
module spi_flash_command_sequencer_unit import sfcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] req_type,
	input  logic [7:0] length,
	input  logic [7:0] data_byte,
	input  logic [7:0] status_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] tx_byte,
	output logic       frame_last,
	output logic [8:0] rx_length
);

	sfcs_frame_t wframe, head;
	logic q_push, q_full, q_pop, q_empty;

	sfcs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .length(length), .data_byte(data_byte),
		.status_byte(status_byte), .q_push(q_push), .q_frame(wframe), .q_full(q_full)
	);

	sfcs_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(q_push), .wdata(wframe), .q_full(q_full),
		.rd(q_pop), .head(head), .q_empty(q_empty)
	);

	sfcs_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .q_pop(q_pop),
		.empty(empty), .pop(pop), .tx_byte(tx_byte), .frame_last(frame_last),
		.rx_length(rx_length)
	);

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import sfcs_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int RANDOM_WORDS = 45;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		logic [2:0] req;
		logic [7:0] len;
		logic [7:0] data;
		logic [7:0] status;
	} word_t;

	typedef struct packed {
		logic [7:0] tx;
		logic       last;
		logic [8:0] rx;
	} frame_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [2:0] req_type = REQ_UNLOCK;
	logic [7:0] length = 8'h00;
	logic [7:0] data_byte = 8'h00;
	logic [7:0] status_byte = 8'h00;
	logic       pop = 1'b0;
	wire        full;
	wire        empty;
	wire  [7:0] tx_byte;
	wire        frame_last;
	wire  [8:0] rx_length;

	spi_flash_command_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.length(length),
		.data_byte(data_byte),
		.status_byte(status_byte),
		.empty(empty),
		.pop(pop),
		.tx_byte(tx_byte),
		.frame_last(frame_last),
		.rx_length(rx_length)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	word_t       words_to_send[$];
	frame_byte_t frame_bytes_due[$];
	word_t       on_bus;
	int          words_taken = 0;
	int          bytes_checked = 0;
	int          errors = 0;

	// sequencer state as the flash sees it
	logic [2:0]  seq_mode = M_IDLE;
	logic [1:0]  seq_step = 2'd0;
	logic [23:0] dev_addr = 24'h0;
	logic [7:0]  prog_buf [BUFFER_DEPTH];
	logic [7:0]  load_ptr = 8'h00;
	logic [7:0]  prog_len = 8'h00;
	logic [8:0]  prog_ptr = 9'h000;
	logic        poll_armed = 1'b0;

	function automatic void queue_frame(input int n, input logic [8:0] rx,
			input logic [7:0] b0, b1, b2, b3, b4, b5);
		logic [47:0] b;
		frame_byte_t fb;
		b = {b5, b4, b3, b2, b1, b0};
		for (int k = 0; k < n; k++) begin
			fb.tx = b[8*k +: 8];
			fb.last = (k == n - 1);
			fb.rx = rx;
			frame_bytes_due.push_back(fb);
		end
		poll_armed = (rx == 9'd2 && n == 1 && b0 == OP_RDSR);
	endfunction

	function automatic logic [7:0] fetch_prog_byte();
		logic [7:0] v;
		v = (prog_ptr < BUFFER_DEPTH) ? prog_buf[prog_ptr[7:0]] : 8'h00;
		prog_ptr = prog_ptr + 9'd1;
		return v;
	endfunction

	function automatic int prog_left();
		return (prog_ptr < prog_len) ? int'(prog_len) - int'(prog_ptr) : 0;
	endfunction

	function automatic void on_frame_done(input logic [7:0] status);
		logic [7:0] op;
		logic [7:0] d0;
		logic [7:0] d1;
		case (seq_mode)
			M_UNLOCK: begin
				if (seq_step >= 2'd1) begin
					seq_mode = M_IDLE;
				end else begin
					seq_step = 2'd1;
					queue_frame(2, 9'd0, OP_WRSR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				end
			end
			M_ERASE: begin
				if (seq_step == 2'd0) begin
					seq_step = 2'd1;
					queue_frame(1, 9'd0, OP_ERASE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				end else if (seq_step == 2'd1) begin
					// busy bit only counts once a status read came back
					if (poll_armed && !status[0]) begin
						seq_step = 2'd2;
						queue_frame(1, 9'd0, OP_WRDI, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
					end else begin
						queue_frame(1, 9'd2, OP_RDSR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
					end
				end else begin
					seq_mode = M_IDLE;
				end
			end
			M_WRITE: begin
				if (seq_step == 2'd0) begin
					seq_step = 2'd1;
					op = (prog_left() >= 2) ? OP_AAI : OP_BPROG;
					d0 = fetch_prog_byte();
					d1 = 8'h00;
					if (op == OP_AAI)
						d1 = fetch_prog_byte();
					queue_frame((op == OP_AAI) ? 6 : 5, 9'd0, op, dev_addr[23:16],
						dev_addr[15:8], dev_addr[7:0], d0, d1);
				end else if (seq_step == 2'd1) begin
					seq_step = 2'd2;
					queue_frame(1, 9'd2, OP_RDSR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				end else if (seq_step == 2'd2) begin
					if (status[0]) begin
						queue_frame(1, 9'd2, OP_RDSR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
					end else if (prog_left() == 0) begin
						seq_step = 2'd3;
						queue_frame(1, 9'd0, OP_WRDI, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
					end else begin
						seq_step = 2'd1;
						d0 = fetch_prog_byte();
						d1 = 8'h00;
						// odd tail pads with zero
						if (prog_left() > 0)
							d1 = fetch_prog_byte();
						queue_frame(3, 9'd0, OP_AAI, d0, d1, 8'h00, 8'h00, 8'h00);
					end
				end else begin
					dev_addr = dev_addr + {16'h0, prog_len};
					seq_mode = M_IDLE;
				end
			end
			default: begin
				seq_mode = M_IDLE;
			end
		endcase
	endfunction

	function automatic void sequencer_accept(input word_t w);
		if (w.req == REQ_DONE) begin
			on_frame_done(w.status);
		end else if (w.req == REQ_LOAD) begin
			if (seq_mode != M_WRITE) begin
				prog_buf[load_ptr] = w.data;
				load_ptr = load_ptr + 8'd1;
			end
		end else if (w.req != REQ_UNUSED && seq_mode == M_IDLE) begin
			case (w.req)
				REQ_UNLOCK: begin
					seq_mode = M_UNLOCK;
					seq_step = 2'd0;
					queue_frame(1, 9'd0, OP_EWSR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				end
				REQ_ERASE: begin
					seq_mode = M_ERASE;
					seq_step = 2'd0;
					queue_frame(1, 9'd0, OP_WREN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				end
				REQ_WRITE: begin
					if (w.len != 8'h00) begin
						prog_len = w.len;
						prog_ptr = 9'h000;
						load_ptr = 8'h00;
						seq_mode = M_WRITE;
						seq_step = 2'd0;
						queue_frame(1, 9'd0, OP_WREN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
					end
				end
				REQ_READ: begin
					seq_mode = M_READ;
					seq_step = 2'd0;
					queue_frame(5, {1'b0, w.len} + 9'd5, OP_READ, dev_addr[23:16],
						dev_addr[15:8], dev_addr[7:0], 8'h00, 8'h00);
				end
				default: begin
					seq_mode = M_READID;
					queue_frame(4, 9'd8, OP_RDID, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				end
			endcase
		end
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add(input logic [2:0] r, input logic [7:0] l, d, s);
		word_t w;
		w = {r, l, d, s};
		words_to_send.push_back(w);
	endfunction

	function automatic void done_any();
		add(REQ_DONE, rnd8(), rnd8(), rnd8());
	endfunction

	function automatic void done_busy();
		add(REQ_DONE, rnd8(), rnd8(), rnd8() | 8'h01);
	endfunction

	function automatic void done_clear();
		add(REQ_DONE, rnd8(), rnd8(), rnd8() & 8'hFE);
	endfunction

	// stray words inside a sequence: requests while busy, loads, unused code
	function automatic void maybe_stray();
		int pick;
		if ($urandom_range(0, 99) < 12) begin
			pick = $urandom_range(0, 2);
			if (pick == 0)
				add(3'($urandom_range(0, 4)), rnd8(), rnd8(), rnd8());
			else if (pick == 1)
				add(REQ_LOAD, rnd8(), rnd8(), rnd8());
			else
				add(REQ_UNUSED, rnd8(), rnd8(), rnd8());
		end
	endfunction

	function automatic int pick_polls(input int max_polls);
		if (max_polls == 0 || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, max_polls);
	endfunction

	function automatic void unlock_seq();
		add(REQ_UNLOCK, rnd8(), rnd8(), rnd8());
		maybe_stray();
		done_any();
		maybe_stray();
		done_any();
	endfunction

	function automatic void erase_seq();
		add(REQ_ERASE, rnd8(), rnd8(), rnd8());
		maybe_stray();
		done_any();
		done_any();
		repeat (pick_polls(3)) done_busy();
		done_clear();
		maybe_stray();
		done_any();
	endfunction

	function automatic void write_seq(input int n, input int max_polls);
		int programs;
		add(REQ_WRITE, 8'(n), rnd8(), rnd8());
		maybe_stray();
		done_any();
		programs = (n >= 2) ? 1 + (n - 1) / 2 : 1;
		repeat (programs) begin
			done_any();
			repeat (pick_polls(max_polls)) done_busy();
			done_clear();
			maybe_stray();
		end
		done_any();
	endfunction

	function automatic void read_seq(input logic [7:0] len);
		add(REQ_READ, len, rnd8(), rnd8());
		maybe_stray();
		done_any();
	endfunction

	function automatic void readid_seq();
		add(REQ_READID, rnd8(), rnd8(), rnd8());
		maybe_stray();
		done_any();
	endfunction

	function automatic bit take_break();
		return ($urandom_range(0, 99) < 28) && !(words_taken >= 262 && words_taken < 322);
	endfunction

	function automatic void flag_field(input string field, input logic [8:0] want,
			input logic [8:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s expected %h got %h", $time, field, want, got);
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				sequencer_accept(on_bus);
				words_taken++;
			end
			if (!push || !full) begin
				if (words_to_send.size() != 0 && !take_break()) begin
					on_bus = words_to_send.pop_front();
					push <= 1'b1;
					req_type <= on_bus.req;
					length <= on_bus.len;
					data_byte <= on_bus.data;
					status_byte <= on_bus.status;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		frame_byte_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (frame_bytes_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: frame byte expected none got %h", $time, tx_byte);
				end else begin
					want = frame_bytes_due.pop_front();
					bytes_checked++;
					flag_field("tx_byte", {1'b0, want.tx}, {1'b0, tx_byte});
					flag_field("frame_last", {8'h00, want.last}, {8'h00, frame_last});
					flag_field("rx_length", want.rx, rx_length);
				end
			end
			pop <= !take_break();
		end
	end

	initial begin
		int total_words;
		int random_end;
		int pick;

		// fill the whole buffer, wrap the load pointer, then an odd-length write
		repeat (256) add(REQ_LOAD, rnd8(), rnd8(), rnd8());
		add(REQ_LOAD, 8'h00, 8'h00, 8'h00);
		add(REQ_LOAD, 8'hFF, 8'hFF, 8'hFF);
		add(REQ_LOAD, rnd8(), rnd8(), rnd8());
		write_seq(3, 1);

		// unlock with a request while busy
		add(REQ_UNLOCK, 8'h00, 8'h00, 8'h00);
		add(REQ_ERASE, 8'hFF, 8'hFF, 8'hFF);
		done_any();
		done_any();
		// erase: clear status before any status read is not trusted
		add(REQ_ERASE, 8'h00, 8'h00, 8'h00);
		done_any();
		add(REQ_DONE, 8'h00, 8'h00, 8'h00);
		add(REQ_DONE, 8'hFF, 8'hFF, 8'hFF);
		add(REQ_DONE, 8'hFF, 8'hFF, 8'h00);
		done_any();
		// single byte program
		add(REQ_WRITE, 8'd1, 8'h00, 8'h00);
		done_any();
		done_any();
		add(REQ_DONE, 8'h00, 8'h00, 8'hFE);
		done_any();
		// empty write, reads at both length extremes, id, idle frame done, unused code
		add(REQ_WRITE, 8'h00, 8'hFF, 8'hFF);
		add(REQ_READ, 8'h00, 8'h00, 8'h00);
		done_any();
		add(REQ_READ, 8'hFF, 8'h00, 8'h00);
		done_any();
		add(REQ_READID, 8'h00, 8'h00, 8'h00);
		done_any();
		add(REQ_DONE, 8'h00, 8'h00, 8'h01);
		add(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF);

		random_end = words_to_send.size() + RANDOM_WORDS;
		while (words_to_send.size() < random_end) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				write_seq(($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
					: $urandom_range(1, 12), 3);
			else if (pick < 50)
				erase_seq();
			else if (pick < 62)
				read_seq(rnd8());
			else if (pick < 72)
				readid_seq();
			else if (pick < 80)
				unlock_seq();
			else if (pick < 90)
				repeat ($urandom_range(1, 6)) add(REQ_LOAD, rnd8(), rnd8(), rnd8());
			else if (pick < 94)
				done_any();
			else if (pick < 97)
				add(REQ_UNUSED, rnd8(), rnd8(), rnd8());
			else
				add(REQ_WRITE, 8'h00, rnd8(), rnd8());
		end
		read_seq(rnd8());
		total_words = words_to_send.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < total_words || frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		$display("ran %0d words through unlock, erase, read, id and write sequences,", words_taken);
		$display("load wrap and stray requests; %0d frame bytes checked", bytes_checked);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("%0t: timed out, %0d words taken, %0d frame bytes outstanding",
			$time, words_taken, frame_bytes_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/sfcs_pkg.sv
design/sfcs_front.sv
design/sfcs_fifo.sv
design/sfcs_back.sv
design/spi_flash_command_sequencer_unit.sv
test/tb.sv
